>>> rtl/murmur64a_stream_hash_core_macros.svh
// Assertion helpers shared by the hash core. They assume the enclosing
// module has ports named i_clk and i_rst_n.
`ifndef MURMUR64A_STREAM_HASH_CORE_MACROS_SVH
`define MURMUR64A_STREAM_HASH_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MM64_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MM64_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mm64_pkg.sv
package mm64_pkg;

    localparam int DATA_W = 64;
    localparam int NB_W   = 4;
    localparam int LEN_W  = 31;
    localparam int CNT_W  = 32;

    localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MUR_M_LO = MUR_M[31:0];
    localparam logic [31:0] MUR_M_HI = MUR_M[63:32];
    localparam int          MUR_R    = 47;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_M,
        S_INIT_W,
        S_K1_M,
        S_K1_W,
        S_K2_M,
        S_K2_W,
        S_H_M,
        S_H_W,
        S_T_M,
        S_T_W,
        S_F_M,
        S_F_W
    } t_state;

    // Operand fed to the shared multiplier.
    typedef enum logic [2:0] {
        OP_LEN,
        OP_WORD,
        OP_K,
        OP_HK,
        OP_HT,
        OP_HF
    } t_opsel;

    // Where the product lands.
    typedef enum logic [2:0] {
        WB_NONE,
        WB_INIT,
        WB_K1,
        WB_K2,
        WB_HASH,
        WB_FIN
    } t_wbsel;

    typedef struct packed {
        logic   load;
        logic   mul_go;
        t_opsel opsel;
        t_wbsel wbsel;
    } t_dp_cmd;

    typedef struct packed {
        logic nb_full;
        logic nb_zero;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/mm64_in_if.sv
interface mm64_in_if;
    import mm64_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_word;
    logic [NB_W-1:0]   valid_bytes;
    logic              first_item;
    logic              last_item;
    logic [LEN_W-1:0]  message_length;

    modport source (
        output valid, data_word, valid_bytes, first_item, last_item, message_length,
        input  ready
    );

    modport sink (
        input  valid, data_word, valid_bytes, first_item, last_item, message_length,
        output ready
    );
endinterface

>>> rtl/mm64_out_if.sv
interface mm64_out_if;
    import mm64_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] hash_value;
    logic              length_mismatch;

    modport source (
        output valid, hash_value, length_mismatch,
        input  ready
    );

    modport sink (
        input  valid, hash_value, length_mismatch,
        output ready
    );
endinterface

>>> rtl/murmur64a_stream_hash_core.sv
// Streaming MurmurHash64A core.
// Input channel i_in carries one little-endian 64-bit word per request with
// its valid byte count and first/last marks; the first request of a message
// also carries the total length. Output channel o_out returns one result per
// message closed by a last mark: the finalized hash and a flag set when the
// delivered byte count differs from the stated length. The seed is written
// through i_cfg_wr_en / i_cfg_wr_data; the user must do so only while the core
// is idle, as the core itself does not enforce it.
// One 64-bit multiplier by the constant M, used in a multiply state and a
// write-back state, is shared by every step. A request occupies the core for
// its multiplies: a full word uses 3, a partial word 1, an empty word 0, and
// a first or last mark adds 1 each.
// Ready is high only while no request is in progress.
// The output register lets the core take the next request while a result
// waits; if the receiver stalls and a second result is done, the core holds
// it in the multiplier until the output register frees.
// Synchronous reset clears the seed to zero, closes any open message and
// empties the output register.
module murmur64a_stream_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    mm64_in_if.sink     i_in,
    mm64_out_if.source  o_out
);
    import mm64_pkg::*;

    `include "murmur64a_stream_hash_core_macros.svh"

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_fin_load;
    logic     w_out_slot_free;
    logic     w_dp_idle;

    mm64_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_valid_bytes (i_in.valid_bytes),
        .i_first_item  (i_in.first_item),
        .i_last_item   (i_in.last_item),
        .i_stat        (w_stat),
        .o_in_ready    (w_in_ready),
        .o_cmd         (w_cmd)
    );

    mm64_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_data_word       (i_in.data_word),
        .i_valid_bytes     (i_in.valid_bytes),
        .i_first_item      (i_in.first_item),
        .i_last_item       (i_in.last_item),
        .i_message_length  (i_in.message_length),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_hash_value      (o_out.hash_value),
        .o_length_mismatch (o_out.length_mismatch)
    );

    assign i_in.ready = w_in_ready;

    assign w_fin_load      = (w_cmd.wbsel == WB_FIN);
    assign w_out_slot_free = !o_out.valid || o_out.ready;
    assign w_dp_idle       = (w_cmd.wbsel == WB_NONE) && !w_cmd.mul_go;

    `MM64_ASSERT_NOW(a_fin_slot_free, w_fin_load, w_out_slot_free, "result over a pending one")
    `MM64_ASSERT_NEXT(a_fin_shows, w_fin_load, o_out.valid, "loaded result not presented")
    `MM64_ASSERT_NOW(a_ready_quiet, i_in.ready, w_dp_idle, "datapath busy while taking requests")

endmodule

>>> rtl/mm64_mulm.sv
module mm64_mulm (
    input  logic        i_clk,
    input  logic        i_go,
    input  logic [63:0] i_a,
    output logic [63:0] o_p
);
    import mm64_pkg::*;

    logic [63:0] r_p0;
    logic [31:0] r_p1;
    logic [31:0] r_p2;
    logic [63:0] w_p0;
    logic [31:0] w_p1;
    logic [31:0] w_p2;

    // Low 64 bits of a * M from three 32x32 partial products; the high
    // cross term falls entirely above bit 63.
    assign w_p0 = 64'(i_a[31:0]) * 64'(MUR_M_LO);
    assign w_p1 = i_a[63:32] * MUR_M_LO;
    assign w_p2 = i_a[31:0] * MUR_M_HI;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_p0 <= w_p0;
            r_p1 <= w_p1;
            r_p2 <= w_p2;
        end
    end

    assign o_p = r_p0 + {r_p1 + r_p2, 32'h0000_0000};

endmodule

>>> rtl/mm64_dp.sv
module mm64_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [63:0]               i_cfg_wr_data,
    input  logic [63:0]               i_data_word,
    input  logic [3:0]                i_valid_bytes,
    input  logic                      i_first_item,
    input  logic                      i_last_item,
    input  logic [30:0]               i_message_length,
    input  mm64_pkg::t_dp_cmd         i_cmd,
    output mm64_pkg::t_dp_stat        o_stat,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [63:0]               o_hash_value,
    output logic                      o_length_mismatch
);
    import mm64_pkg::*;

    logic [DATA_W-1:0] r_seed;
    logic [DATA_W-1:0] r_hash;
    logic [DATA_W-1:0] r_k;
    logic [DATA_W-1:0] r_word;
    logic [NB_W-1:0]   r_nb;
    logic              r_last;
    logic [LEN_W-1:0]  r_exp;
    logic [CNT_W-1:0]  r_bytes;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_hash;
    logic              r_out_mis;

    logic [NB_W-1:0]   w_nb;
    logic [CNT_W-1:0]  w_base;
    logic [CNT_W:0]    w_sum;
    logic [CNT_W-1:0]  n_bytes;
    logic [DATA_W-1:0] w_tail;
    logic [DATA_W-1:0] w_op;
    logic [DATA_W-1:0] w_prod;
    logic [DATA_W-1:0] w_fin;
    logic              w_out_free;

    // Byte counts above eight count as a full word.
    assign w_nb   = i_valid_bytes[3] ? 4'd8 : i_valid_bytes;
    assign w_base = i_first_item ? '0 : r_bytes;
    assign w_sum  = {1'b0, w_base} + (CNT_W + 1)'(w_nb);
    assign n_bytes = w_sum[CNT_W] ? '1 : w_sum[CNT_W-1:0];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_tail[8*i +: 8] = (NB_W'(i) < r_nb) ? r_word[8*i +: 8] : 8'h00;
        end
    end

    always_comb begin
        unique case (i_cmd.opsel)
            OP_LEN:  w_op = {{(DATA_W - LEN_W){1'b0}}, r_exp};
            OP_WORD: w_op = r_word;
            OP_K:    w_op = r_k;
            OP_HK:   w_op = r_hash ^ r_k;
            OP_HT:   w_op = r_hash ^ w_tail;
            OP_HF:   w_op = r_hash ^ (r_hash >> MUR_R);
            default: w_op = r_word;
        endcase
    end

    mm64_mulm u_mul (
        .i_clk (i_clk),
        .i_go  (i_cmd.mul_go),
        .i_a   (w_op),
        .o_p   (w_prod)
    );

    assign w_fin      = w_prod ^ (w_prod >> MUR_R);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_wr_en) begin
            r_seed <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word  <= i_data_word;
            r_nb    <= w_nb;
            r_last  <= i_last_item;
            r_bytes <= n_bytes;
            if (i_first_item) begin
                r_exp <= i_message_length;
            end
        end
        unique case (i_cmd.wbsel)
            WB_INIT: r_hash <= r_seed ^ w_prod;
            WB_K1:   r_k    <= w_fin;
            WB_K2:   r_k    <= w_prod;
            WB_HASH: r_hash <= w_prod;
            WB_FIN: begin
                r_out_hash <= w_fin;
                r_out_mis  <= (r_bytes != {1'b0, r_exp});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wbsel == WB_FIN) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.nb_full  = r_nb[3];
    assign o_stat.nb_zero  = (r_nb == '0);
    assign o_stat.last     = r_last;
    assign o_stat.out_free = w_out_free;

    assign o_out_valid       = r_out_valid;
    assign o_hash_value      = r_out_hash;
    assign o_length_mismatch = r_out_mis;

endmodule

>>> rtl/mm64_ctrl.sv
module mm64_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [3:0]         i_valid_bytes,
    input  logic               i_first_item,
    input  logic               i_last_item,
    input  mm64_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output mm64_pkg::t_dp_cmd  o_cmd
);
    import mm64_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_in_msg;
    logic   n_in_msg;

    // Picks the first multiply of the data phase for a word, or idle if it needs none.
    function automatic t_state f_route(input logic full, input logic zero, input logic last);
        t_state s;
        if (full) begin
            s = S_K1_M;
        end else if (!zero) begin
            s = S_T_M;
        end else if (last) begin
            s = S_F_M;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_msg <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_msg <= n_in_msg;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_in_msg     = r_in_msg;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.mul_go = 1'b0;
        o_cmd.opsel  = OP_LEN;
        o_cmd.wbsel  = WB_NONE;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_first_item) begin
                        o_cmd.load = 1'b1;
                        n_in_msg   = 1'b1;
                        n_state    = S_INIT_M;
                    end else if (r_in_msg) begin
                        o_cmd.load = 1'b1;
                        n_state    = f_route(i_valid_bytes[3], i_valid_bytes == '0,
                                             i_last_item);
                    end
                end
            end
            S_INIT_M: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.opsel  = OP_LEN;
                n_state      = S_INIT_W;
            end
            S_INIT_W: begin
                o_cmd.wbsel = WB_INIT;
                n_state     = f_route(i_stat.nb_full, i_stat.nb_zero, i_stat.last);
            end
            S_K1_M: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.opsel  = OP_WORD;
                n_state      = S_K1_W;
            end
            S_K1_W: begin
                o_cmd.wbsel = WB_K1;
                n_state     = S_K2_M;
            end
            S_K2_M: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.opsel  = OP_K;
                n_state      = S_K2_W;
            end
            S_K2_W: begin
                o_cmd.wbsel = WB_K2;
                n_state     = S_H_M;
            end
            S_H_M: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.opsel  = OP_HK;
                n_state      = S_H_W;
            end
            S_H_W: begin
                o_cmd.wbsel = WB_HASH;
                n_state     = i_stat.last ? S_F_M : S_IDLE;
            end
            S_T_M: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.opsel  = OP_HT;
                n_state      = S_T_W;
            end
            S_T_W: begin
                o_cmd.wbsel = WB_HASH;
                n_state     = i_stat.last ? S_F_M : S_IDLE;
            end
            S_F_M: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.opsel  = OP_HF;
                n_state      = S_F_W;
            end
            S_F_W: begin
                // The product registers hold while the output slot is busy.
                if (i_stat.out_free) begin
                    o_cmd.wbsel = WB_FIN;
                    n_in_msg    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> bench/tb_murmur64a_stream_hash_core.sv
`timescale 1ns / 100ps

module tb_murmur64a_stream_hash_core;
    import mm64_pkg::*;

    localparam int WORD_BYTES   = 8;
    localparam int IDLE_SETTLE  = 30;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASES       = 6;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        logic [DATA_W-1:0] data_word;
        logic [NB_W-1:0]   valid_bytes;
        logic              first_item;
        logic              last_item;
        logic [LEN_W-1:0]  message_length;
        bit                wait_drain;
    } word_req_t;

    typedef struct {
        logic [DATA_W-1:0] hash_value;
        logic              length_mismatch;
    } digest_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [63:0] cfg_wr_data = '0;

    mm64_in_if  in_ch ();
    mm64_out_if out_ch ();

    murmur64a_stream_hash_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // Shadow of the hash core state.
    logic [63:0]      seed_shadow = '0;
    logic [63:0]      hash_acc    = '0;
    logic [CNT_W-1:0] byte_count  = '0;
    logic [LEN_W-1:0] stated_len  = '0;
    bit               msg_open    = 1'b0;

    word_req_t pending_reqs[$];
    digest_t   expected_digests[$];
    word_req_t cur_req;

    int reqs_queued   = 0;
    int reqs_accepted = 0;
    int error_count   = 0;
    int tx_gap        = 0;
    int tx_burst      = 0;
    int rx_gap        = 0;
    int rx_burst      = 0;
    int idle_cycles   = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] mix_word(input logic [63:0] k);
        k = k * MUR_M;
        k = k ^ (k >> MUR_R);
        k = k * MUR_M;
        return k;
    endfunction

    function automatic logic [63:0] fold_final(input logic [63:0] h);
        h = h ^ (h >> MUR_R);
        h = h * MUR_M;
        h = h ^ (h >> MUR_R);
        return h;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a burst with none.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 99) == 0) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_error(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        end
    endtask

    task automatic predict_digest(input word_req_t r);
        logic [3:0]  nb;
        logic [63:0] mask;
        digest_t     d;
        if (r.first_item) begin
            hash_acc   = seed_shadow ^ ({33'd0, r.message_length} * MUR_M);
            byte_count = '0;
            stated_len = r.message_length;
            msg_open   = 1'b1;
        end else if (!msg_open) begin
            // A stray request while idle leaves everything untouched.
            return;
        end
        nb = (r.valid_bytes > WORD_BYTES) ? 4'(WORD_BYTES) : r.valid_bytes;
        if (nb == WORD_BYTES) begin
            hash_acc = (hash_acc ^ mix_word(r.data_word)) * MUR_M;
        end else if (nb != 0) begin
            mask     = (64'd1 << (8 * nb)) - 64'd1;
            hash_acc = (hash_acc ^ (r.data_word & mask)) * MUR_M;
        end
        if (byte_count > 32'hFFFF_FFFF - nb) begin
            byte_count = 32'hFFFF_FFFF;
        end else begin
            byte_count = byte_count + nb;
        end
        if (!r.last_item) return;
        d.hash_value      = fold_final(hash_acc);
        d.length_mismatch = (byte_count != {1'b0, stated_len});
        expected_digests.push_back(d);
        msg_open = 1'b0;
    endtask

    task automatic push_req(input logic [63:0] data, input logic [3:0] nb, input bit first,
                            input bit last, input logic [LEN_W-1:0] len, input bit drain);
        word_req_t r;
        r.data_word      = data;
        r.valid_bytes    = nb;
        r.first_item     = first;
        r.last_item      = last;
        r.message_length = len;
        r.wait_drain     = drain;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // One message with random content; about a fifth of them are broken on purpose.
    task automatic queue_message(output int n_words);
        int               vbs[24];
        int               i;
        int               kind;
        int               total;
        logic [LEN_W-1:0] len;
        bit               open_end;
        n_words = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
        kind    = $urandom_range(0, 99);
        for (i = 0; i < n_words; i++) begin
            vbs[i] = (i == n_words - 1) ? $urandom_range(0, 8) : WORD_BYTES;
        end
        if (kind >= 80 && kind < 85) begin
            vbs[$urandom_range(0, n_words - 1)] = $urandom_range(9, 15);
        end else if (kind >= 85 && kind < 90 && n_words > 1) begin
            vbs[$urandom_range(0, n_words - 2)] = $urandom_range(1, 7);
        end
        total = 0;
        for (i = 0; i < n_words; i++) begin
            total += (vbs[i] > WORD_BYTES) ? WORD_BYTES : vbs[i];
        end
        len = LEN_W'(total);
        if (kind >= 90 && kind < 95) begin
            len = ($urandom_range(0, 1) == 1) ? LEN_W'($urandom) : LEN_W'(total + 1);
        end
        // Without a last request the next first request abandons this message.
        open_end = (kind >= 95);
        for (i = 0; i < n_words; i++) begin
            push_req({$urandom, $urandom}, NB_W'(vbs[i]), i == 0,
                     (i == n_words - 1) && !open_end,
                     (i == 0) ? len : LEN_W'($urandom),
                     (i == 0) && ($urandom_range(0, 149) == 0));
        end
    endtask

    task automatic write_seed(input logic [63:0] value);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        seed_shadow = value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (reqs_accepted != reqs_queued || expected_digests.size() != 0) begin
            @(posedge i_clk);
        end
        // A request that ends no message may still be in the multiplier.
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_digest(cur_req);
                reqs_accepted++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Hold the request until it is taken.
            end else if (tx_gap > 0) begin
                tx_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].wait_drain || expected_digests.size() == 0)) begin
                cur_req = pending_reqs.pop_front();
                in_ch.data_word      <= cur_req.data_word;
                in_ch.valid_bytes    <= cur_req.valid_bytes;
                in_ch.first_item     <= cur_req.first_item;
                in_ch.last_item      <= cur_req.last_item;
                in_ch.message_length <= cur_req.message_length;
                in_ch.valid          <= 1'b1;
                tx_gap = pick_gap(tx_burst);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        digest_t want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_digests.size() == 0) begin
                    report_error("unexpected result", out_ch.hash_value, '0);
                end else begin
                    want = expected_digests.pop_front();
                    if (out_ch.hash_value !== want.hash_value) begin
                        report_error("hash_value", out_ch.hash_value, want.hash_value);
                    end
                    if (out_ch.length_mismatch !== want.length_mismatch) begin
                        report_error("length_mismatch", {63'd0, out_ch.length_mismatch},
                                     {63'd0, want.length_mismatch});
                    end
                end
                rx_gap = pick_gap(rx_burst);
            end else if (rx_gap > 0) begin
                rx_gap--;
            end else if ($urandom_range(0, 15) == 0) begin
                rx_gap = pick_gap(rx_burst);
            end
            out_ch.ready <= (rx_gap == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_murmur64a_stream_hash_core: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        int made;
        int n;
        int vb;
        in_ch.valid          = 1'b0;
        in_ch.data_word      = '0;
        in_ch.valid_bytes    = '0;
        in_ch.first_item     = 1'b0;
        in_ch.last_item      = 1'b0;
        in_ch.message_length = '0;
        out_ch.ready         = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset seed.
        push_req({$urandom, $urandom}, 4'd0, 1'b1, 1'b1, 31'd0, 1'b0);
        push_req({$urandom, $urandom}, 4'd0, 1'b1, 1'b1, 31'd5, 1'b0);
        push_req('1, 4'd8, 1'b1, 1'b1, 31'd8, 1'b0);
        push_req('0, 4'd8, 1'b1, 1'b1, 31'd8, 1'b0);
        for (vb = 1; vb < WORD_BYTES; vb++) begin
            push_req('1, NB_W'(vb), 1'b1, 1'b1, LEN_W'(vb), 1'b0);
        end
        push_req({$urandom, $urandom}, 4'd8, 1'b1, 1'b0, 31'd11, 1'b0);
        push_req({$urandom, $urandom}, 4'd3, 1'b0, 1'b1, 31'd0, 1'b0);
        // Byte counts above eight count as a full word.
        push_req('1, 4'd15, 1'b1, 1'b1, 31'd8, 1'b0);
        // Ignored: no message is open.
        push_req({$urandom, $urandom}, 4'd5, 1'b0, 1'b1, 31'd5, 1'b0);
        // The first message is abandoned by the second first request.
        push_req({$urandom, $urandom}, 4'd8, 1'b1, 1'b0, 31'd16, 1'b0);
        push_req({$urandom, $urandom}, 4'd2, 1'b1, 1'b1, 31'd2, 1'b0);
        // Partial word ahead of the last request.
        push_req({$urandom, $urandom}, 4'd3, 1'b1, 1'b0, 31'd11, 1'b0);
        push_req({$urandom, $urandom}, 4'd8, 1'b0, 1'b1, 31'd0, 1'b0);
        push_req({$urandom, $urandom}, 4'd0, 1'b1, 1'b1, 31'h7FFF_FFFF, 1'b1);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_seed(64'hFFFF_FFFF_FFFF_FFFF);
                2: write_seed(64'h0);
                4: write_seed(64'h8000_0000_0000_0000);
                default: write_seed({$urandom, $urandom});
            endcase
            made = 0;
            while (made < RANDOM_ITEMS / PHASES) begin
                if ($urandom_range(0, 19) == 0) begin
                    push_req({$urandom, $urandom}, NB_W'($urandom), 1'b0, 1'($urandom),
                             LEN_W'($urandom), 1'b0);
                end else begin
                    queue_message(n);
                    made += n;
                end
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("tb_murmur64a_stream_hash_core: PASS");
        end else begin
            $display("tb_murmur64a_stream_hash_core: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/mm64_pkg.sv
rtl/mm64_in_if.sv
rtl/mm64_out_if.sv
rtl/mm64_mulm.sv
rtl/mm64_dp.sv
rtl/mm64_ctrl.sv
rtl/murmur64a_stream_hash_core.sv
bench/tb_murmur64a_stream_hash_core.sv
